/* rtl/core/dds_header_mip_layout_defines.svh */
// ----------------------------------------------------------------------------
// DDS header layout assertion macros
// Shared concurrent assertion forms for the layout block.
// ----------------------------------------------------------------------------
`ifndef DDS_HEADER_MIP_LAYOUT_DEFINES_SVH
`define DDS_HEADER_MIP_LAYOUT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DHML_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dhml same-cycle check failed");

// next-cycle implication, checked out of reset
`define DHML_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dhml next-cycle check failed");

`endif

/* rtl/core/dhml_pkg.sv */
// ----------------------------------------------------------------------------
// DDS header layout package
// Shared types, codes and helpers for the header front end and surface walker.
// ----------------------------------------------------------------------------
package dhml_pkg;

    localparam int unsigned HEADER_BYTES   = 128;
    localparam int unsigned MAX_MIP_LEVELS = 10;
    localparam int unsigned QUEUE_DEPTH    = 2;
    localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MAGIC    = 3'd1;
    localparam logic [2:0] ST_HSIZE    = 3'd2;
    localparam logic [2:0] ST_TYPE     = 3'd3;
    localparam logic [2:0] ST_FORMAT   = 3'd4;
    localparam logic [2:0] ST_CORRUPT  = 3'd5;
    localparam logic [2:0] ST_MIPS     = 3'd6;

    localparam logic [1:0] KIND_2D     = 2'd0;
    localparam logic [1:0] KIND_CUBE   = 2'd1;
    localparam logic [1:0] KIND_VOLUME = 2'd2;

    localparam logic [3:0] FMT_BGR8    = 4'd0;
    localparam logic [3:0] FMT_RGB8    = 4'd1;
    localparam logic [3:0] FMT_DXT1    = 4'd6;
    localparam logic [3:0] FMT_DXT3    = 4'd7;
    localparam logic [3:0] FMT_DXT5    = 4'd8;
    localparam logic [3:0] FMT_RGBA16F = 4'd9;
    localparam logic [3:0] FMT_RGBA32F = 4'd10;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  fmt;
        logic [1:0]  kind;
        logic        cube_inc;
        logic [3:0]  mips;
        logic [31:0] width;
        logic [31:0] height;
        logic [31:0] depth;
        logic [31:0] length;
    } job_t;

    // bytes per pixel, or per 4x4 block for the DXT formats
    function automatic logic [4:0] bytes_per_unit(input logic [3:0] fmt);
        logic [4:0] b;
        case (fmt)
            4'd0, 4'd1:             b = 5'd3;
            4'd2, 4'd3, 4'd4, 4'd5: b = 5'd4;
            4'd6, 4'd9:             b = 5'd8;
            default:                b = 5'd16;
        endcase
        return b;
    endfunction

endpackage

/* rtl/core/dhml_front.sv */
// ----------------------------------------------------------------------------
// DDS header front end
// Collects header words, validates the header and queues one job per header.
// ----------------------------------------------------------------------------
module dhml_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [31:0]         header_word,
    input  logic                first_word,
    input  logic [31:0]         file_length,
    output logic                push,
    output dhml_pkg::job_t      job
);
    import dhml_pkg::*;

    logic [4:0]  word_count_reg, word_count_next;
    logic        active_reg, active_next;
    logic        magic_ok_reg, magic_ok_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] fields_reg [14];

    logic        act_eff;
    logic [4:0]  wc_eff;
    logic        slot_hit;
    logic [3:0]  slot;

    logic [31:0] flags, caps2, pff, cc, mips32;
    logic [1:0]  kind;
    logic        kind_bad, cube_inc;
    logic [3:0]  fmt;
    logic        fmt_ok;
    logic [2:0]  status;

    assign act_eff = first_word | active_reg;
    assign wc_eff  = first_word ? 5'd0 : word_count_reg;

    always_comb
    begin
        slot_hit = 1'b1;
        slot     = 4'd0;
        unique case (wc_eff)
            5'd1:    slot = 4'd0;
            5'd2:    slot = 4'd1;
            5'd3:    slot = 4'd2;
            5'd4:    slot = 4'd3;
            5'd6:    slot = 4'd4;
            5'd7:    slot = 4'd5;
            5'd20:   slot = 4'd6;
            5'd21:   slot = 4'd7;
            5'd22:   slot = 4'd8;
            5'd23:   slot = 4'd9;
            5'd24:   slot = 4'd10;
            5'd25:   slot = 4'd11;
            5'd26:   slot = 4'd12;
            5'd28:   slot = 4'd13;
            default: slot_hit = 1'b0;
        endcase
    end

    assign flags = fields_reg[1];
    assign pff   = fields_reg[6];
    assign cc    = fields_reg[7];
    assign caps2 = fields_reg[13];

    always_comb
    begin
        kind     = KIND_2D;
        kind_bad = 1'b0;
        cube_inc = 1'b0;
        if (caps2 == 32'd0)
        begin
            kind = KIND_2D;
        end
        else if (caps2[9])
        begin
            kind     = KIND_CUBE;
            cube_inc = (caps2[15:10] != 6'h3f);
        end
        else if (caps2[21])
        begin
            kind = KIND_VOLUME;
        end
        else
        begin
            kind_bad = 1'b1;
        end
    end

    always_comb
    begin
        fmt    = FMT_BGR8;
        fmt_ok = 1'b0;
        if (pff[2])
        begin
            fmt_ok = 1'b1;
            if (cc == 32'h31545844)      fmt = FMT_DXT1;
            else if (cc == 32'h33545844) fmt = FMT_DXT3;
            else if (cc == 32'h35545844) fmt = FMT_DXT5;
            else if (cc == 32'd113)      fmt = FMT_RGBA16F;
            else if (cc == 32'd116)      fmt = FMT_RGBA32F;
            else                         fmt_ok = 1'b0;
        end
        else if (pff[6])
        begin
            fmt_ok = 1'b1;
            if (fields_reg[9] == 32'h00ff0000 && fields_reg[10] == 32'h0000ff00
                && fields_reg[11] == 32'h000000ff)
                fmt = FMT_BGR8;
            else if (fields_reg[9] == 32'h000000ff && fields_reg[10] == 32'h0000ff00
                && fields_reg[11] == 32'h00ff0000)
                fmt = FMT_RGB8;
            else
                fmt_ok = 1'b0;
            if (fmt_ok && fields_reg[8] == 32'd32)
            begin
                if (!pff[0] || fields_reg[12] == 32'd0)
                    fmt = fmt + 4'd2;
                else
                    fmt = fmt + 4'd4;
            end
        end
    end

    assign mips32 = flags[17] ? fields_reg[5] : 32'd1;

    always_comb
    begin
        if (!magic_ok_reg || length_reg <= HEADER_BYTES)
            status = ST_MAGIC;
        else if (fields_reg[0] != 32'd124)
            status = ST_HSIZE;
        else if (kind_bad)
            status = ST_TYPE;
        else if (!fmt_ok)
            status = ST_FORMAT;
        else if (mips32 > MAX_MIP_LEVELS)
            status = ST_MIPS;
        else
            status = ST_OK;
    end

    always_comb
    begin
        job.status   = status;
        job.fmt      = (status == ST_OK || status == ST_MIPS) ? fmt : FMT_BGR8;
        job.kind     = (status == ST_OK || status == ST_MIPS || status == ST_FORMAT)
                       ? kind : KIND_2D;
        job.cube_inc = (status == ST_OK || status == ST_MIPS || status == ST_FORMAT)
                       ? cube_inc : 1'b0;
        job.mips     = mips32[3:0];
        job.width    = fields_reg[3];
        job.height   = fields_reg[2];
        job.depth    = (kind == KIND_VOLUME) ? fields_reg[4] : 32'd1;
        job.length   = length_reg;
    end

    assign push = accept && act_eff && (wc_eff == 5'd31);

    always_comb
    begin
        word_count_next = word_count_reg;
        active_next     = active_reg;
        magic_ok_next   = magic_ok_reg;
        length_next     = length_reg;
        if (accept)
        begin
            if (first_word)
                length_next = file_length;
            if (act_eff)
            begin
                if (wc_eff == 5'd0)
                    magic_ok_next = (header_word == 32'h20534444);
                if (wc_eff == 5'd31)
                begin
                    active_next     = 1'b0;
                    word_count_next = 5'd0;
                end
                else
                begin
                    active_next     = 1'b1;
                    word_count_next = wc_eff + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg <= 5'd0;
            active_reg     <= 1'b0;
            magic_ok_reg   <= 1'b0;
            length_reg     <= 32'd0;
        end
        else
        begin
            word_count_reg <= word_count_next;
            active_reg     <= active_next;
            magic_ok_reg   <= magic_ok_next;
            length_reg     <= length_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && act_eff && slot_hit)
            fields_reg[slot] <= header_word;
    end

endmodule

/* rtl/core/dhml_queue.sv */
// ----------------------------------------------------------------------------
// DDS header job queue
// Short first-in first-out store between the front end and the walker.
// ----------------------------------------------------------------------------
module dhml_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  dhml_pkg::job_t      push_job,
    input  logic                pop,
    output dhml_pkg::job_t      head_job,
    output logic                empty,
    output logic                full
);
    import dhml_pkg::*;

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    job_t              store_reg [QUEUE_DEPTH];

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_job = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_job;
    end

endmodule

/* rtl/core/dhml_back.sv */
// ----------------------------------------------------------------------------
// DDS surface walker
// Walks slices and mip levels of a queued job and emits one result per surface, or a status result that ends the run.
// ----------------------------------------------------------------------------
`include "dds_header_mip_layout_defines.svh"

module dhml_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_ready,
    input  dhml_pkg::job_t      head_job,
    output logic                pop,
    output logic                done,
    output logic                surface_valid,
    output logic [2:0]          slice_index,
    output logic [3:0]          mip_level,
    output logic [31:0]         data_offset,
    output logic [31:0]         data_size,
    output logic [3:0]          pixel_format,
    output logic [1:0]          texture_kind,
    output logic [2:0]          status,
    output logic                cube_incomplete,
    output logic                run_last
);
    import dhml_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL1 = 2'd1;
    localparam logic [1:0] S_MUL2 = 2'd2;
    localparam logic [1:0] S_CHK  = 2'd3;

    localparam logic [32:0] SAT = 33'h1_0000_0000;

    logic [1:0]  state_reg, state_next;
    job_t        job_reg, job_next;
    logic [2:0]  s_reg, s_next;
    logic [3:0]  m_reg, m_next;
    logic [31:0] w_reg, w_next, h_reg, h_next, d_reg, d_next;
    logic [31:0] off_reg, off_next;
    logic [63:0] p_reg, p_next;

    logic        done_reg, done_next;
    logic        sv_reg, sv_next;
    logic [2:0]  si_reg, si_next;
    logic [3:0]  ml_reg, ml_next;
    logic [31:0] do_reg, do_next, ds_reg, ds_next;
    logic [3:0]  pf_reg, pf_next;
    logic [1:0]  tk_reg, tk_next;
    logic [2:0]  st_reg, st_next;
    logic        ci_reg, ci_next;
    logic        rl_reg, rl_next;

    logic        is_dxt;
    logic [31:0] bw, bh;
    logic [32:0] a_sat;
    logic [37:0] sz;
    logic [38:0] end_pos;
    logic        corrupt, last_mip, last_slice;
    logic [2:0]  slices_m1;

    assign is_dxt = (job_reg.fmt == FMT_DXT1) || (job_reg.fmt == FMT_DXT3)
                    || (job_reg.fmt == FMT_DXT5);
    assign bw = !is_dxt ? w_reg : ((w_reg[31:2] == 30'd0) ? 32'd1 : {2'b00, w_reg[31:2]});
    assign bh = !is_dxt ? h_reg : ((h_reg[31:2] == 30'd0) ? 32'd1 : {2'b00, h_reg[31:2]});

    // clamp the registered product to the saturation point
    assign a_sat   = (p_reg > {31'd0, SAT}) ? SAT : p_reg[32:0];
    assign sz      = 38'(a_sat) * 38'(bytes_per_unit(job_reg.fmt));
    assign end_pos = 39'(off_reg) + 39'(sz);
    assign corrupt = end_pos > 39'(job_reg.length);

    assign slices_m1  = (job_reg.kind == KIND_CUBE) ? 3'd5 : 3'd0;
    assign last_mip   = (m_reg == job_reg.mips - 4'd1);
    assign last_slice = (s_reg == slices_m1);

    assign pop = (state_reg == S_IDLE) && job_ready;

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        s_next     = s_reg;
        m_next     = m_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        d_next     = d_reg;
        off_next   = off_reg;
        p_next     = p_reg;
        done_next  = 1'b0;
        sv_next    = 1'b0;
        si_next    = 3'd0;
        ml_next    = 4'd0;
        do_next    = off_reg;
        ds_next    = 32'd0;
        pf_next    = job_reg.fmt;
        tk_next    = job_reg.kind;
        st_next    = ST_OK;
        ci_next    = job_reg.cube_inc;
        rl_next    = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_ready)
                begin
                    job_next = head_job;
                    off_next = 32'(HEADER_BYTES);
                    s_next   = 3'd0;
                    m_next   = 4'd0;
                    w_next   = head_job.width;
                    h_next   = head_job.height;
                    d_next   = head_job.depth;
                    if (head_job.status != ST_OK || head_job.mips == 4'd0)
                    begin
                        // one status result ends the run
                        done_next = 1'b1;
                        do_next   = 32'(HEADER_BYTES);
                        pf_next   = head_job.fmt;
                        tk_next   = head_job.kind;
                        st_next   = head_job.status;
                        ci_next   = head_job.cube_inc;
                    end
                    else
                    begin
                        state_next = S_MUL1;
                    end
                end
            end
            S_MUL1:
            begin
                p_next     = bw * bh;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                if (a_sat[32])
                    p_next = (d_reg != 32'd0) ? {31'd0, SAT} : 64'd0;
                else
                    p_next = a_sat[31:0] * d_reg;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                done_next = 1'b1;
                if (corrupt)
                begin
                    st_next    = ST_CORRUPT;
                    state_next = S_IDLE;
                end
                else
                begin
                    sv_next  = 1'b1;
                    si_next  = s_reg;
                    ml_next  = m_reg;
                    ds_next  = sz[31:0];
                    rl_next  = last_mip && last_slice;
                    off_next = off_reg + sz[31:0];
                    w_next   = (w_reg > 32'd1) ? (w_reg >> 1) : w_reg;
                    h_next   = (h_reg > 32'd1) ? (h_reg >> 1) : h_reg;
                    d_next   = (d_reg > 32'd1) ? (d_reg >> 1) : d_reg;
                    if (!last_mip)
                    begin
                        m_next     = m_reg + 4'd1;
                        state_next = S_MUL1;
                    end
                    else if (!last_slice)
                    begin
                        // advance to the next face and reload the base size
                        s_next     = s_reg + 3'd1;
                        m_next     = 4'd0;
                        w_next     = job_reg.width;
                        h_next     = job_reg.height;
                        d_next     = job_reg.depth;
                        state_next = S_MUL1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            s_reg     <= 3'd0;
            m_reg     <= 4'd0;
            off_reg   <= 32'(HEADER_BYTES);
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            s_reg     <= s_next;
            m_reg     <= m_next;
            off_reg   <= off_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        w_reg   <= w_next;
        h_reg   <= h_next;
        d_reg   <= d_next;
        p_reg   <= p_next;
        sv_reg  <= sv_next;
        si_reg  <= si_next;
        ml_reg  <= ml_next;
        do_reg  <= do_next;
        ds_reg  <= ds_next;
        pf_reg  <= pf_next;
        tk_reg  <= tk_next;
        st_reg  <= st_next;
        ci_reg  <= ci_next;
        rl_reg  <= rl_next;
    end

    assign done            = done_reg;
    assign surface_valid   = sv_reg;
    assign slice_index     = si_reg;
    assign mip_level       = ml_reg;
    assign data_offset     = do_reg;
    assign data_size       = ds_reg;
    assign pixel_format    = pf_reg;
    assign texture_kind    = tk_reg;
    assign status          = st_reg;
    assign cube_incomplete = ci_reg;
    assign run_last        = rl_reg;

    `DHML_ASSERT_IMP(a_status_ends_run, done && !surface_valid, run_last)
    `DHML_ASSERT_IMP(a_surface_ok, done && surface_valid, status == ST_OK)
    `DHML_ASSERT_NXT(a_surface_gap, done && surface_valid && !run_last, !done)

endmodule

/* rtl/core/dds_header_mip_layout.sv */
// ----------------------------------------------------------------------------
// DDS header mip layout: one header word accepted per cycle; busy only while
// the two-entry job queue is full. Each job passes from the front end through
// the queue to the surface walker, which gives one status result or walks the
// surfaces, each in two multiplies and one check.
// Reset is asynchronous active low and empties the queue and both control units.
// ----------------------------------------------------------------------------
module dds_header_mip_layout
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] header_word,
    input  logic        first_word,
    input  logic [31:0] file_length,
    output logic        done,
    output logic        surface_valid,
    output logic [2:0]  slice_index,
    output logic [3:0]  mip_level,
    output logic [31:0] data_offset,
    output logic [31:0] data_size,
    output logic [3:0]  pixel_format,
    output logic [1:0]  texture_kind,
    output logic [2:0]  status,
    output logic        cube_incomplete,
    output logic        run_last
);
    import dhml_pkg::*;

    logic push, pop, empty, full;
    job_t push_job, head_job;

    assign busy = full;

    dhml_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (start && !busy),
        .header_word (header_word),
        .first_word  (first_word),
        .file_length (file_length),
        .push        (push),
        .job         (push_job)
    );

    dhml_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (empty),
        .full     (full)
    );

    dhml_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_ready       (!empty),
        .head_job        (head_job),
        .pop             (pop),
        .done            (done),
        .surface_valid   (surface_valid),
        .slice_index     (slice_index),
        .mip_level       (mip_level),
        .data_offset     (data_offset),
        .data_size       (data_size),
        .pixel_format    (pixel_format),
        .texture_kind    (texture_kind),
        .status          (status),
        .cube_incomplete (cube_incomplete),
        .run_last        (run_last)
    );

endmodule

/* tb/dds_header_mip_layout_test.sv */
// ----------------------------------------------------------------------------
// DDS header mip layout testbench
// Streams 32-word DDS headers into the layout block with random start gaps.
// A scoreboard predicts every surface and status result from the header
// words and checks each done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dds_header_mip_layout_test;
    import dhml_pkg::*;

    localparam logic [3:0] FMT_BGRX8   = 4'd2;
    localparam logic [3:0] FMT_RGBX8   = 4'd3;
    localparam logic [3:0] FMT_BGRA8   = 4'd4;
    localparam logic [3:0] FMT_RGBA8   = 4'd5;
    localparam int         FMT_UNKNOWN = 11;
    localparam logic [31:0] DDS_MAGIC  = 32'h20534444;
    localparam logic [31:0] FL_MIPS    = 32'h00020000;
    localparam logic [31:0] CAPS2_CUBE = 32'h00000200;
    localparam logic [31:0] CAPS2_ALLF = 32'h0000FC00;
    localparam logic [31:0] CAPS2_VOL  = 32'h00200000;
    localparam longint unsigned SAT    = 64'h1_0000_0000;
    localparam int WATCHDOG_LIMIT      = 3000;

    typedef struct packed {
        logic        surface_valid;
        logic [2:0]  slice_index;
        logic [3:0]  mip_level;
        logic [31:0] data_offset;
        logic [31:0] data_size;
        logic [3:0]  pixel_format;
        logic [1:0]  texture_kind;
        logic [2:0]  status;
        logic        cube_incomplete;
        logic        run_last;
    } surface_t;

    class layout_scoreboard;
        surface_t    pending[$];
        logic [31:0] fields[14];
        logic [4:0]  word_idx;
        logic [31:0] file_len;
        logic [31:0] offset;
        bit          active;
        bit          magic_ok;
        int          mismatches;
        int          checked;
        int          headers;

        function new();
            word_idx = 0;
            active = 0;
            magic_ok = 0;
            offset = HEADER_BYTES;
            file_len = 0;
            mismatches = 0;
            checked = 0;
            headers = 0;
            foreach (fields[i]) fields[i] = 0;
        endfunction

        function int field_slot(int w);
            case (w)
                1: return 0;   2: return 1;   3: return 2;   4: return 3;
                6: return 4;   7: return 5;
                20: return 6;  21: return 7;  22: return 8;  23: return 9;
                24: return 10; 25: return 11; 26: return 12; 28: return 13;
                default: return -1;
            endcase
        endfunction

        function longint unsigned mul_sat(longint unsigned a, longint unsigned b);
            longint unsigned p;
            if (a == 0 || b == 0) return 0;
            if (a > SAT / b) return SAT;
            p = a * b;
            return (p > SAT) ? SAT : p;
        endfunction

        function longint unsigned unit_bytes(logic [3:0] fmt);
            case (fmt)
                FMT_BGR8, FMT_RGB8:                       return 3;
                FMT_BGRX8, FMT_RGBX8, FMT_BGRA8, FMT_RGBA8: return 4;
                FMT_DXT1, FMT_RGBA16F:                    return 8;
                default:                                  return 16;
            endcase
        endfunction

        function longint unsigned surface_bytes(logic [3:0] fmt, longint unsigned w,
                                                longint unsigned h, longint unsigned d);
            longint unsigned bw, bh;
            if (fmt == FMT_DXT1 || fmt == FMT_DXT3 || fmt == FMT_DXT5)
            begin
                bw = (w / 4 != 0) ? w / 4 : 1;
                bh = (h / 4 != 0) ? h / 4 : 1;
                return mul_sat(mul_sat(bw, bh), d) * unit_bytes(fmt);
            end
            return mul_sat(mul_sat(w, h), d) * unit_bytes(fmt);
        endfunction

        function void push(bit v, int s, int m, logic [31:0] off, logic [31:0] sz,
                           logic [3:0] fmt, logic [1:0] kind, logic [2:0] st,
                           bit ci, bit last);
            surface_t r;
            r.surface_valid = v;
            r.slice_index = 3'(s);
            r.mip_level = 4'(m);
            r.data_offset = off;
            r.data_size = sz;
            r.pixel_format = fmt;
            r.texture_kind = kind;
            r.status = st;
            r.cube_incomplete = ci;
            r.run_last = last;
            pending.push_back(r);
        endfunction

        function void predict_layout();
            logic [31:0] caps2, pff, cc, mips;
            logic [1:0] kind;
            logic [3:0] fmt;
            int fmt_i, slices, n;
            bit ci;
            longint unsigned dw, dh, dd, sz;
            caps2 = fields[13];
            pff = fields[6];
            cc = fields[7];
            kind = KIND_2D;
            ci = 0;
            fmt_i = FMT_UNKNOWN;
            n = 0;
            headers++;
            offset = HEADER_BYTES;
            if (!magic_ok || file_len <= HEADER_BYTES)
            begin
                push(0, 0, 0, offset, 0, 0, KIND_2D, ST_MAGIC, 0, 1);
                return;
            end
            if (fields[0] != 124)
            begin
                push(0, 0, 0, offset, 0, 0, KIND_2D, ST_HSIZE, 0, 1);
                return;
            end
            if (caps2 == 0) kind = KIND_2D;
            else if (caps2 & CAPS2_CUBE)
            begin
                kind = KIND_CUBE;
                ci = ((caps2 & CAPS2_ALLF) != CAPS2_ALLF);
            end
            else if (caps2 & CAPS2_VOL) kind = KIND_VOLUME;
            else
            begin
                push(0, 0, 0, offset, 0, 0, KIND_2D, ST_TYPE, 0, 1);
                return;
            end
            if (pff & 32'h4)
            begin
                if (cc == 32'h31545844) fmt_i = FMT_DXT1;
                else if (cc == 32'h33545844) fmt_i = FMT_DXT3;
                else if (cc == 32'h35545844) fmt_i = FMT_DXT5;
                else if (cc == 113) fmt_i = FMT_RGBA16F;
                else if (cc == 116) fmt_i = FMT_RGBA32F;
            end
            else if (pff & 32'h40)
            begin
                if (fields[9] == 32'h00ff0000 && fields[10] == 32'h0000ff00 &&
                    fields[11] == 32'h000000ff) fmt_i = FMT_BGR8;
                else if (fields[9] == 32'h000000ff && fields[10] == 32'h0000ff00 &&
                         fields[11] == 32'h00ff0000) fmt_i = FMT_RGB8;
                if (fmt_i <= 1 && fields[8] == 32)
                    fmt_i += (!pff[0] || fields[12] == 0) ? 2 : 4;
            end
            if (fmt_i > 10)
            begin
                push(0, 0, 0, offset, 0, 0, kind, ST_FORMAT, ci, 1);
                return;
            end
            fmt = 4'(fmt_i);
            mips = (fields[1] & FL_MIPS) ? fields[5] : 32'd1;
            if (mips > MAX_MIP_LEVELS)
            begin
                push(0, 0, 0, offset, 0, fmt, kind, ST_MIPS, ci, 1);
                return;
            end
            slices = (kind == KIND_CUBE) ? 6 : 1;
            for (int s = 0; s < slices; s++)
            begin
                dw = fields[3];
                dh = fields[2];
                dd = (kind == KIND_VOLUME) ? fields[4] : 1;
                for (int m = 0; m < mips; m++)
                begin
                    sz = surface_bytes(fmt, dw, dh, dd);
                    if (64'(offset) + sz > 64'(file_len))
                    begin
                        push(0, 0, 0, offset, 0, fmt, kind, ST_CORRUPT, ci, 1);
                        return;
                    end
                    push(1, s, m, offset, sz[31:0], fmt, kind, ST_OK, ci, 0);
                    n++;
                    offset += sz[31:0];
                    if (dw > 1) dw >>= 1;
                    if (dh > 1) dh >>= 1;
                    if (dd > 1) dd >>= 1;
                end
            end
            if (n == 0) push(0, 0, 0, offset, 0, fmt, kind, ST_OK, ci, 1);
            else pending[pending.size() - 1].run_last = 1;
        endfunction

        function void note_request(logic [31:0] w, logic first, logic [31:0] len);
            int slot;
            if (first)
            begin
                active = 1;
                word_idx = 0;
                file_len = len;
                offset = HEADER_BYTES;
            end
            if (!active) return;
            if (word_idx == 0) magic_ok = (w == DDS_MAGIC);
            slot = field_slot(word_idx);
            if (slot >= 0) fields[slot] = w;
            if (word_idx == 31)
            begin
                active = 0;
                word_idx = 0;
                predict_layout();
            end
            else word_idx++;
        endfunction

        function void check_surface(surface_t got);
            surface_t exp_r;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            if (got !== exp_r)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at result %0d\n  expected %p\n  actual   %p",
                             checked, exp_r, got);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] header_word;
    logic        first_word;
    logic [31:0] file_length;
    logic        done;
    logic        surface_valid;
    logic [2:0]  slice_index;
    logic [3:0]  mip_level;
    logic [31:0] data_offset;
    logic [31:0] data_size;
    logic [3:0]  pixel_format;
    logic [1:0]  texture_kind;
    logic [2:0]  status;
    logic        cube_incomplete;
    logic        run_last;

    layout_scoreboard sb;
    bit          gaps_on;
    int          idle_count;
    int          words_sent;
    logic [31:0] hdr[32];

    dds_header_mip_layout DUT
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .header_word     (header_word),
        .first_word      (first_word),
        .file_length     (file_length),
        .done            (done),
        .surface_valid   (surface_valid),
        .slice_index     (slice_index),
        .mip_level       (mip_level),
        .data_offset     (data_offset),
        .data_size       (data_size),
        .pixel_format    (pixel_format),
        .texture_kind    (texture_kind),
        .status          (status),
        .cube_incomplete (cube_incomplete),
        .run_last        (run_last)
    );

    initial clk = 0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_surface({surface_valid, slice_index, mip_level, data_offset,
                              data_size, pixel_format, texture_kind, status,
                              cube_incomplete, run_last});
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done) idle_count <= 0;
        else idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no activity for %0d cycles", WATCHDOG_LIMIT);
            $display("dds_header_mip_layout test failed");
            $finish;
        end
    end

    task automatic send_word(logic [31:0] w, logic f, logic [31:0] len);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            start = 0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        start = 1;
        header_word = w;
        first_word = f;
        file_length = len;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_request(w, f, len);
        words_sent++;
        @(negedge clk);
    endtask

    // restart_at >= 0 drops a fresh first word in before header word restart_at
    task automatic send_header(logic [31:0] len, int restart_at);
        for (int i = 0; i < 32; i++)
        begin
            if (i == restart_at)
                send_word(DDS_MAGIC, 1, $urandom);
            send_word(hdr[i], i == 0, (i == 0) ? len : $urandom);
        end
    endtask

    task automatic build_header(logic [31:0] caps2, int fmt, logic [31:0] wd,
                                logic [31:0] ht, logic [31:0] dp, logic [31:0] mips);
        foreach (hdr[i]) hdr[i] = $urandom;
        hdr[0] = DDS_MAGIC;
        hdr[1] = 124;
        hdr[2] = (mips != 1 || $urandom_range(0, 1)) ? ($urandom | FL_MIPS)
                                                      : ($urandom & ~FL_MIPS);
        hdr[3] = ht;
        hdr[4] = wd;
        hdr[6] = dp;
        hdr[7] = mips;
        hdr[28] = caps2;
        hdr[20] = 32'h40;
        hdr[22] = (fmt < 2) ? 24 : 32;
        hdr[23] = fmt[0] ? 32'h000000ff : 32'h00ff0000;
        hdr[24] = 32'h0000ff00;
        hdr[25] = fmt[0] ? 32'h00ff0000 : 32'h000000ff;
        hdr[26] = (fmt == FMT_BGRA8 || fmt == FMT_RGBA8) ? 32'hff000000 : 32'h0;
        if (fmt == FMT_BGRA8 || fmt == FMT_RGBA8) hdr[20] = 32'h41;
        else if ($urandom_range(0, 1)) hdr[20] = 32'h41;
        case (fmt)
            FMT_DXT1:    hdr[21] = 32'h31545844;
            FMT_DXT3:    hdr[21] = 32'h33545844;
            FMT_DXT5:    hdr[21] = 32'h35545844;
            FMT_RGBA16F: hdr[21] = 113;
            FMT_RGBA32F: hdr[21] = 116;
            FMT_UNKNOWN: hdr[21] = $urandom_range(0, 1) ? 32'h30545844 : 117;
            default:     hdr[21] = $urandom;
        endcase
        if (fmt >= 6)
        begin
            hdr[20] = 32'h4;
            hdr[22] = $urandom;
        end
    endtask

    function automatic logic [31:0] rand_caps2(int sel);
        case (sel)
            0: return 0;
            1: return CAPS2_CUBE | CAPS2_ALLF | ($urandom & 32'hFFDF_0000);
            2: return CAPS2_CUBE | ($urandom & 32'h0000F800);
            default: return CAPS2_VOL | ($urandom & 32'hFFDF_01FF) | 32'h1;
        endcase
    endfunction

    function automatic logic [31:0] rand_dim();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 1;
            2: return 32'h8000_0000 | $urandom;
            default: return $urandom_range(2, 48);
        endcase
    endfunction

    function automatic logic [31:0] rand_len();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 130);
            default: return 129 + $urandom_range(0, 30000);
        endcase
    endfunction

    initial
    begin
        sb = new();
        rst_n = 0;
        start = 0;
        header_word = 0;
        first_word = 0;
        file_length = 0;
        gaps_on = 0;
        words_sent = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        gaps_on = 1;
        // directed: stray word, then headers for the main layout paths
        send_word(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
        build_header(0, FMT_BGR8, 4, 4, 1, 3);
        send_header(32'hFFFF_FFFF, -1);
        build_header(rand_caps2(2), FMT_DXT5, 16, 4, 1, 3);
        send_header(32'hFFFF_FFFF, -1);
        build_header(rand_caps2(3), FMT_RGBA16F, 4, 8, 4, 4);
        send_header(32'hFFFF_FFFF, -1);
        build_header(0, FMT_RGBA32F, 16, 16, 1, 10);
        send_header(3000, -1);

        while (words_sent < 150)
        begin
            if (words_sent > 120) gaps_on = 0;
            case ($urandom_range(0, 9))
                0:
                begin
                    foreach (hdr[i]) hdr[i] = $urandom;
                    send_header($urandom, -1);
                end
                1: send_word($urandom, 0, $urandom);
                default:
                begin
                    build_header(rand_caps2($urandom_range(0, 3)), $urandom_range(0, 11),
                                 rand_dim(), rand_dim(), $urandom_range(0, 9),
                                 $urandom_range(0, 12) == 0 ? $urandom_range(11, 15)
                                                            : $urandom_range(0, 6));
                    if ($urandom_range(0, 15) == 0) hdr[1] = $urandom;
                    send_header(rand_len(), $urandom_range(0, 12) == 0
                                            ? $urandom_range(1, 31) : -1);
                end
            endcase
        end
        start = 0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            sb.mismatches++;
            $display("%0d results never arrived", sb.pending.size());
        end
        $display("sent %0d header words, %0d headers parsed, %0d results checked",
                 words_sent, sb.headers, sb.checked);
        $display("mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0)
            $display("dds_header_mip_layout test passed");
        else
            $display("dds_header_mip_layout test failed");
        $finish;
    end

endmodule
